FILE: hw/rtl/three_level_priority_fifo_assert.svh
// Assertion macros shared by the checker.
`ifndef THREE_LEVEL_PRIORITY_FIFO_ASSERT_SVH
`define THREE_LEVEL_PRIORITY_FIFO_ASSERT_SVH

// Same-cycle implication, quiet while in reset.
`define TLPF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, quiet while in reset.
`define TLPF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/tlpf_pkg.sv
package tlpf_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int DATA_W    = 32;
	localparam int LANES     = 3;

	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_POP  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPRI = 2'd3
	} status_t;

	typedef struct packed {
		status_t status;
		logic    empty;
		logic    full;
		logic    pop_ok;
	} res_t;

endpackage

FILE: hw/rtl/three_level_priority_fifo.sv
// Strict-priority queue over three FIFO lanes sharing one synchronous memory.
// The result strobe (done) is registered and comes in the cycle that follows the accepting edge.
// No new item is taken while busy is high; busy holds for the cycle the result shows.
// Reset (arst_n low) empties all lanes; stored words stay undefined.
// The receiver cannot stall: each result shows for exactly one cycle.
module three_level_priority_fifo #(
	parameter int DEPTH = tlpf_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               kind,
	input  logic signed [tlpf_pkg::DATA_W-1:0] data_in,
	input  logic [1:0]                         priority_req,
	output logic                               done,
	output logic signed [tlpf_pkg::DATA_W-1:0] data_out,
	output logic [1:0]                         status,
	output logic                               empty_flag,
	output logic                               full_flag
);
	import tlpf_pkg::*;

	localparam int WORDS  = LANES * DEPTH;
	localparam int ADDR_W = $clog2(WORDS);

	logic                     accept;
	logic                     busy_q;
	logic                     wr_en;
	logic [ADDR_W-1:0]        wr_addr;
	logic                     rd_en;
	logic [ADDR_W-1:0]        rd_addr;
	logic signed [DATA_W-1:0] rd_data;
	res_t                     res_q;

	assign accept = start && !busy_q;

	// Hold off the next transfer while the result is on the ports.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else begin
			busy_q <= accept;
		end
	end

	tlpf_ctrl #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.kind         (kind),
		.priority_req (priority_req),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.res_q        (res_q)
	);

	tlpf_store #(
		.WORDS  (WORDS),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (data_in),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign busy       = busy_q;
	assign done       = busy_q;
	assign data_out   = res_q.pop_ok ? rd_data : '0;
	assign status     = res_q.status;
	assign empty_flag = res_q.empty;
	assign full_flag  = res_q.full;

endmodule

FILE: hw/rtl/tlpf_store.sv
module tlpf_store #(
	parameter int WORDS  = tlpf_pkg::LANES * tlpf_pkg::DEPTH_DEF,
	parameter int ADDR_W = $clog2(WORDS)
) (
	input  logic                                clk,
	input  logic                                wr_en,
	input  logic [ADDR_W-1:0]                   wr_addr,
	input  logic signed [tlpf_pkg::DATA_W-1:0]  wr_data,
	input  logic                                rd_en,
	input  logic [ADDR_W-1:0]                   rd_addr,
	output logic signed [tlpf_pkg::DATA_W-1:0]  rd_data
);
	import tlpf_pkg::*;

	logic signed [DATA_W-1:0] mem [WORDS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: hw/rtl/tlpf_ctrl.sv
module tlpf_ctrl #(
	parameter int DEPTH  = tlpf_pkg::DEPTH_DEF,
	parameter int ADDR_W = $clog2(3 * DEPTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic                kind,
	input  logic [1:0]          priority_req,
	output logic                wr_en,
	output logic [ADDR_W-1:0]   wr_addr,
	output logic                rd_en,
	output logic [ADDR_W-1:0]   rd_addr,
	output tlpf_pkg::res_t      res_q
);
	import tlpf_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [PTR_W-1:0] head_q [LANES];
	logic [PTR_W-1:0] tail_q [LANES];
	logic [CNT_W-1:0] cnt_q  [LANES];
	logic [CNT_W-1:0] total_q;
	logic [CNT_W-1:0] total_nxt;

	logic [1:0]       push_lane;
	logic [1:0]       pop_lane;
	logic [PTR_W-1:0] tail_sel;
	logic [PTR_W-1:0] head_sel;
	logic             is_full;
	logic             is_empty;
	logic             push_ok;
	logic             pop_ok;
	status_t          status_d;

	function automatic logic [ADDR_W-1:0] lane_base(input logic [1:0] lane);
		logic [ADDR_W-1:0] b;
		case (lane)
			2'd1:    b = ADDR_W'(DEPTH);
			2'd2:    b = ADDR_W'(2 * DEPTH);
			default: b = '0;
		endcase
		return b;
	endfunction

	function automatic logic [PTR_W-1:0] step_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign push_lane = priority_req - 2'd1;
	assign pop_lane  = (cnt_q[2] != '0) ? 2'd2 : ((cnt_q[1] != '0) ? 2'd1 : 2'd0);
	assign is_full   = (total_q == CNT_W'(DEPTH));
	assign is_empty  = (total_q == '0);
	assign push_ok   = accept && (kind == KIND_PUSH) && !is_full && (priority_req != 2'd0);
	assign pop_ok    = accept && (kind == KIND_POP) && !is_empty;

	always_comb begin
		case (push_lane)
			2'd1:    tail_sel = tail_q[1];
			2'd2:    tail_sel = tail_q[2];
			default: tail_sel = tail_q[0];
		endcase
		case (pop_lane)
			2'd1:    head_sel = head_q[1];
			2'd2:    head_sel = head_q[2];
			default: head_sel = head_q[0];
		endcase
	end

	always_comb begin
		if (kind == KIND_PUSH) begin
			if (is_full) begin
				status_d = ST_FULL;
			end else if (priority_req == 2'd0) begin
				status_d = ST_BADPRI;
			end else begin
				status_d = ST_OK;
			end
		end else begin
			status_d = is_empty ? ST_EMPTY : ST_OK;
		end
	end

	always_comb begin
		total_nxt = total_q;
		if (push_ok) begin
			total_nxt = total_q + CNT_W'(1);
		end else if (pop_ok) begin
			total_nxt = total_q - CNT_W'(1);
		end
	end

	assign wr_en   = push_ok;
	assign wr_addr = lane_base(push_lane) + ADDR_W'(tail_sel);
	assign rd_en   = pop_ok;
	assign rd_addr = lane_base(pop_lane) + ADDR_W'(head_sel);

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		logic do_push;
		logic do_pop;
		assign do_push = push_ok && (push_lane == 2'(i));
		assign do_pop  = pop_ok && (pop_lane == 2'(i));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i]  <= '0;
			end else begin
				if (do_push) begin
					tail_q[i] <= step_ptr(tail_q[i]);
					cnt_q[i]  <= cnt_q[i] + CNT_W'(1);
				end
				if (do_pop) begin
					head_q[i] <= step_ptr(head_q[i]);
					cnt_q[i]  <= cnt_q[i] - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			res_q   <= '0;
		end else begin
			total_q <= total_nxt;
			if (accept) begin
				res_q.status <= status_d;
				res_q.empty  <= (total_nxt == '0);
				res_q.full   <= (total_nxt == CNT_W'(DEPTH));
				res_q.pop_ok <= pop_ok;
			end
		end
	end

endmodule

FILE: hw/rtl/tlpf_checker.sv
`include "three_level_priority_fifo_assert.svh"

module tlpf_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               start,
	input logic                               busy,
	input logic                               done,
	input logic signed [tlpf_pkg::DATA_W-1:0] data_out,
	input logic [1:0]                         status,
	input logic                               empty_flag,
	input logic                               full_flag
);
	import tlpf_pkg::*;

	`TLPF_ASSERT_NEXT(a_done_follows, start && !busy, done, "no result after a transfer")
	`TLPF_ASSERT_NOW(a_reject_zero, done && (status != ST_OK), data_out == '0, "rejected data not zero")
	`TLPF_ASSERT_NOW(a_empty_flag, done && (status == ST_EMPTY), empty_flag, "empty reject without empty flag")
	`TLPF_ASSERT_NOW(a_full_flag, done && (status == ST_FULL), full_flag && !empty_flag, "full reject without full flag")

endmodule

bind three_level_priority_fifo tlpf_checker u_tlpf_checker (.*);

FILE: sim/three_level_priority_fifo_tb.sv
`timescale 1ns / 100ps

module three_level_priority_fifo_tb;
	import tlpf_pkg::*;

	localparam int DEPTH       = DEPTH_DEF;
	localparam int RAND_BLOCKS = 27;
	localparam int BLOCK_LEN   = 64;
	localparam int IDLE_LIMIT  = 1000;
	localparam int DRAIN_WAIT  = 8;

	localparam int LANE_LOW  = 0;
	localparam int LANE_MID  = 1;
	localparam int LANE_HIGH = 2;

	localparam logic [1:0] PRI_NONE = 2'd0;
	localparam logic [1:0] PRI_LOW  = 2'd1;
	localparam logic [1:0] PRI_MID  = 2'd2;
	localparam logic [1:0] PRI_HIGH = 2'd3;

	typedef struct packed {
		logic              kind;
		logic [DATA_W-1:0] data;
		logic [1:0]        pri;
		logic              typed;
		logic [DATA_W-1:0] exp_data;
		status_t           exp_status;
		logic              exp_empty;
		logic              exp_full;
	} stim_row_t;

	typedef struct {
		logic [DATA_W-1:0] data;
		status_t           status;
		logic              empty;
		logic              full;
	} pq_result_t;

	localparam stim_row_t DIR_TAB [24] = '{
		'{KIND_POP,  32'h0000_0000, PRI_NONE, 1'b1, 32'h0, ST_EMPTY,  1'b1, 1'b0},
		'{KIND_PUSH, 32'hFFFF_FFFF, PRI_NONE, 1'b1, 32'h0, ST_BADPRI, 1'b1, 1'b0},
		'{KIND_PUSH, 32'h7FFF_FFFF, PRI_LOW,  1'b1, 32'h0, ST_OK,     1'b0, 1'b0},
		'{KIND_PUSH, 32'h8000_0000, PRI_MID,  1'b1, 32'h0, ST_OK,     1'b0, 1'b0},
		'{KIND_PUSH, 32'hFFFF_FFFF, PRI_HIGH, 1'b1, 32'h0, ST_OK,     1'b0, 1'b0},
		'{KIND_PUSH, 32'h0000_0000, PRI_LOW,  1'b0, 32'h0, ST_OK,     1'b0, 1'b0},
		'{KIND_PUSH, 32'h0000_0001, PRI_MID,  1'b0, 32'h0, ST_OK,     1'b0, 1'b0},
		'{KIND_PUSH, 32'h5555_5555, PRI_HIGH, 1'b0, 32'h0, ST_OK,     1'b0, 1'b0},
		'{KIND_PUSH, 32'hAAAA_AAAA, PRI_LOW,  1'b0, 32'h0, ST_OK,     1'b0, 1'b0},
		'{KIND_PUSH, 32'h1234_5678, PRI_MID,  1'b0, 32'h0, ST_OK,     1'b0, 1'b0},
		'{KIND_PUSH, 32'h8765_4321, PRI_HIGH, 1'b0, 32'h0, ST_OK,     1'b0, 1'b0},
		'{KIND_PUSH, 32'h0F0F_0F0F, PRI_LOW,  1'b0, 32'h0, ST_OK,     1'b0, 1'b0},
		'{KIND_PUSH, 32'hF0F0_F0F0, PRI_LOW,  1'b0, 32'h0, ST_OK,     1'b0, 1'b0},
		'{KIND_PUSH, 32'h0000_FFFF, PRI_MID,  1'b0, 32'h0, ST_OK,     1'b0, 1'b0},
		'{KIND_PUSH, 32'hFFFF_0000, PRI_HIGH, 1'b0, 32'h0, ST_OK,     1'b0, 1'b0},
		'{KIND_PUSH, 32'h3C3C_3C3C, PRI_LOW,  1'b0, 32'h0, ST_OK,     1'b0, 1'b0},
		'{KIND_PUSH, 32'hC3C3_C3C3, PRI_MID,  1'b0, 32'h0, ST_OK,     1'b0, 1'b0},
		'{KIND_PUSH, 32'h8000_0001, PRI_HIGH, 1'b0, 32'h0, ST_OK,     1'b0, 1'b0},
		'{KIND_PUSH, 32'h1111_1111, PRI_HIGH, 1'b1, 32'h0, ST_FULL,   1'b0, 1'b1},
		'{KIND_PUSH, 32'h2222_2222, PRI_NONE, 1'b1, 32'h0, ST_FULL,   1'b0, 1'b1},
		'{KIND_POP,  32'hDEAD_BEEF, PRI_HIGH, 1'b0, 32'h0, ST_OK,     1'b0, 1'b0},
		'{KIND_PUSH, 32'h3333_3333, PRI_NONE, 1'b1, 32'h0, ST_BADPRI, 1'b0, 1'b0},
		'{KIND_POP,  32'hCAFE_F00D, PRI_NONE, 1'b0, 32'h0, ST_OK,     1'b0, 1'b0},
		'{KIND_POP,  32'h0000_0000, PRI_LOW,  1'b0, 32'h0, ST_OK,     1'b0, 1'b0}
	};

	localparam logic [DATA_W-1:0] EDGE_WORDS [4] = '{
		32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000
	};
	localparam int PUSH_BIAS [3] = '{20, 50, 85};

	logic                     clk          = 1'b0;
	logic                     arst_n       = 1'b0;
	logic                     start        = 1'b0;
	logic                     kind         = KIND_PUSH;
	logic signed [DATA_W-1:0] data_in      = '0;
	logic [1:0]               priority_req = PRI_NONE;
	logic                     busy;
	logic                     done;
	logic signed [DATA_W-1:0] data_out;
	logic [1:0]               status;
	logic                     empty_flag;
	logic                     full_flag;

	// shadow of the three lanes
	logic [DATA_W-1:0] lane_mem [LANES][DEPTH];
	int                head_ptr [LANES] = '{0, 0, 0};
	int                tail_ptr [LANES] = '{0, 0, 0};
	int                lane_cnt [LANES] = '{0, 0, 0};
	int                occupancy = 0;

	pq_result_t pending_results [$];
	pq_result_t want;
	int         mismatches  = 0;
	int         idle_cycles = 0;

	three_level_priority_fifo #(
		.DEPTH(DEPTH)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.data_in     (data_in),
		.priority_req(priority_req),
		.done        (done),
		.data_out    (data_out),
		.status      (status),
		.empty_flag  (empty_flag),
		.full_flag   (full_flag)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic pq_result_t pq_apply(logic k, logic [DATA_W-1:0] d, logic [1:0] p);
		pq_result_t r;
		int         lane;
		r.data   = '0;
		r.status = ST_OK;
		if (k == KIND_PUSH) begin
			if (occupancy >= DEPTH) begin
				r.status = ST_FULL;
			end else if (p == PRI_NONE) begin
				r.status = ST_BADPRI;
			end else begin
				lane = int'(p) - 1;
				lane_mem[lane][tail_ptr[lane]] = d;
				tail_ptr[lane] = (tail_ptr[lane] + 1) % DEPTH;
				lane_cnt[lane]++;
				occupancy++;
			end
		end else if (occupancy == 0) begin
			r.status = ST_EMPTY;
		end else begin
			// serve the highest non-empty lane
			if (lane_cnt[LANE_HIGH] != 0)
				lane = LANE_HIGH;
			else if (lane_cnt[LANE_MID] != 0)
				lane = LANE_MID;
			else
				lane = LANE_LOW;
			r.data = lane_mem[lane][head_ptr[lane]];
			head_ptr[lane] = (head_ptr[lane] + 1) % DEPTH;
			lane_cnt[lane]--;
			occupancy--;
		end
		r.empty = (occupancy == 0);
		r.full  = (occupancy == DEPTH);
		return r;
	endfunction

	// Enter and leave at a falling edge; start stays high after the transfer.
	task automatic send_item(stim_row_t row, int gap);
		pq_result_t r;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		kind         <= row.kind;
		data_in      <= row.data;
		priority_req <= row.pri;
		start        <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		r = pq_apply(row.kind, row.data, row.pri);
		if (row.typed) begin
			r.data   = row.exp_data;
			r.status = row.exp_status;
			r.empty  = row.exp_empty;
			r.full   = row.exp_full;
		end
		pending_results.push_back(r);
		@(negedge clk);
	endtask

	task automatic hold_until_drained();
		start <= 1'b0;
		do @(negedge clk); while (pending_results.size() != 0);
	endtask

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: data=%h status=%0d empty=%b full=%b",
						data_out, status, empty_flag, full_flag);
			end else begin
				want = pending_results.pop_front();
				if (data_out !== want.data || status !== want.status ||
						empty_flag !== want.empty || full_flag !== want.full) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch at %0t: exp data=%h status=%0d empty=%b full=%b, got data=%h status=%0d empty=%b full=%b",
							$realtime, want.data, want.status, want.empty, want.full,
							data_out, status, empty_flag, full_flag);
				end
			end
		end
	end

	// Count cycles with neither a transfer nor a result.
	always @(posedge clk) begin
		if ((start && busy === 1'b0) || done === 1'b1)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		stim_row_t row;
		int        push_pct;
		int        gap_max;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (DIR_TAB[i])
			send_item(DIR_TAB[i], $urandom_range(0, 1) ? $urandom_range(0, 15) : 0);
		hold_until_drained();

		for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
			// vary the push bias so the queue swings between empty and full
			push_pct = PUSH_BIAS[$urandom_range(0, 2)];
			gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 15;
			if (blk == RAND_BLOCKS / 2)
				hold_until_drained();
			for (int n = 0; n < BLOCK_LEN; n++) begin
				row      = '0;
				row.kind = ($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_POP;
				row.pri  = ($urandom_range(0, 15) == 0) ? PRI_NONE : 2'($urandom_range(1, 3));
				row.data = ($urandom_range(0, 7) == 0) ? EDGE_WORDS[$urandom_range(0, 3)]
					: DATA_W'($urandom);
				send_item(row, $urandom_range(0, gap_max));
			end
		end

		hold_until_drained();
		repeat (DRAIN_WAIT) @(negedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
